@@ rtl/core/icmpe_pkg.sv @@
package icmpe_pkg;

  // header layout
  localparam int unsigned HdrLen    = 42;
  localparam int unsigned EthLen    = 14;
  localparam int unsigned IpEnd     = 34;

  localparam logic [5:0] PosEtHi    = 6'd12;
  localparam logic [5:0] PosEtLo    = 6'd13;
  localparam logic [5:0] PosIdHi    = 6'd18;
  localparam logic [5:0] PosIdLo    = 6'd19;
  localparam logic [5:0] PosTtl     = 6'd22;
  localparam logic [5:0] PosProto   = 6'd23;
  localparam logic [5:0] PosIpCkHi  = 6'd24;
  localparam logic [5:0] PosIpCkLo  = 6'd25;
  localparam logic [5:0] PosSrcIp   = 6'd26;
  localparam logic [5:0] PosDstIp   = 6'd30;
  localparam logic [5:0] PosType    = 6'd34;
  localparam logic [5:0] PosCode    = 6'd35;
  localparam logic [5:0] PosIcCkHi  = 6'd36;
  localparam logic [5:0] PosIcCkLo  = 6'd37;
  localparam logic [5:0] PosLast    = 6'd41;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;
  localparam logic [7:0]  IcmpEchoReq   = 8'd8;
  localparam logic [7:0]  IcmpEchoRep   = 8'd0;

  // configuration
  localparam logic       CfgIdxTtl    = 1'b0;
  localparam logic       CfgIdxIdent  = 1'b1;
  localparam logic [7:0]  TtlReset    = 8'd64;
  localparam logic [15:0] IdentReset  = 16'd24851;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_DROP = 2'd1,
    VERDICT_TX   = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] verdict;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic collect_wr;
    logic eval_sum;
    logic eval_fold;
    logic out_ld;
    logic pass_ld;
    logic frame_reset;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pos_last;
    logic k_last;
    logic out_free;
    logic frame_last;
  } dp_status_t;

endpackage

@@ rtl/core/icmpe_ram.sv @@
module icmpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/icmpe_dp.sv @@
module icmpe_dp
  import icmpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_item_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [5:0]  pos_q, pos_d;
  logic [5:0]  k_q, k_d;
  logic        last_q;
  logic [19:0] acc_q, acc_d;
  logic [7:0]  et_hi_q, et_lo_q, proto_q, type_q, code_q, ck_hi_q, ck_lo_q;
  logic [7:0]  ttl_q;
  logic [15:0] ident_q;
  logic [1:0]  verdict_q, verdict_d;
  logic [20:0] ip_sum_q;
  logic [17:0] ic_sum_q;
  logic [15:0] ip_ck_q, ic_ck_q;
  logic [16:0] ip_f1, ic_f1, ip_f2, ic_f2;
  logic        out_valid_q;
  out_item_t   out_q;
  logic [5:0]  raddr;
  logic [7:0]  rdata;
  logic [7:0]  sub_byte;
  logic        is_tx;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q   <= TtlReset;
      ident_q <= IdentReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxTtl) begin
        ttl_q <= cfg_data_i[7:0];
      end else if (cfg_index_i == CfgIdxIdent) begin
        ident_q <= cfg_data_i;
      end
    end
  end

  // header store
  icmpe_ram #(
    .Width(8),
    .Depth(HdrLen)
  ) u_hdr (
    .clk_i  (clk_i),
    .we_i   (cmd_i.collect_wr),
    .waddr_i(pos_q),
    .wdata_i(in_item_i.frame_byte),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // counters and running ip header sum
  always_comb begin
    pos_d = pos_q;
    k_d   = k_q;
    acc_d = acc_q;
    if (cmd_i.collect_wr) begin
      pos_d = pos_q + 6'd1;
      if (pos_q >= 6'(EthLen) && pos_q < 6'(IpEnd) && pos_q != PosIdHi &&
          pos_q != PosIdLo && pos_q != PosTtl && pos_q != PosIpCkHi &&
          pos_q != PosIpCkLo) begin
        if (pos_q[0]) begin
          acc_d = acc_q + {12'd0, in_item_i.frame_byte};
        end else begin
          acc_d = acc_q + {4'd0, in_item_i.frame_byte, 8'd0};
        end
      end
    end
    if (cmd_i.out_ld) begin
      k_d = k_q + 6'd1;
    end
    if (cmd_i.frame_reset) begin
      pos_d = '0;
      k_d   = '0;
      acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      k_q   <= '0;
      acc_q <= '0;
    end else begin
      pos_q <= pos_d;
      k_q   <= k_d;
      acc_q <= acc_d;
    end
  end

  // capture of the header fields that steer the decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.collect_wr) begin
      last_q <= in_item_i.frame_last;
      case (pos_q)
        PosEtHi:   et_hi_q <= in_item_i.frame_byte;
        PosEtLo:   et_lo_q <= in_item_i.frame_byte;
        PosProto:  proto_q <= in_item_i.frame_byte;
        PosType:   type_q  <= in_item_i.frame_byte;
        PosCode:   code_q  <= in_item_i.frame_byte;
        PosIcCkHi: ck_hi_q <= in_item_i.frame_byte;
        PosIcCkLo: ck_lo_q <= in_item_i.frame_byte;
        default: ;
      endcase
    end
  end

  // classification on the held byte count
  always_comb begin
    if (pos_q < 6'(EthLen)) begin
      verdict_d = VERDICT_DROP;
    end else if ({et_hi_q, et_lo_q} != EtherTypeIpv4) begin
      verdict_d = VERDICT_PASS;
    end else if (pos_q < 6'(IpEnd)) begin
      verdict_d = VERDICT_DROP;
    end else if (proto_q != ProtoIcmp) begin
      verdict_d = VERDICT_PASS;
    end else if (pos_q < 6'(HdrLen)) begin
      verdict_d = VERDICT_DROP;
    end else if (type_q == IcmpEchoReq) begin
      verdict_d = VERDICT_TX;
    end else if (type_q == IcmpEchoRep) begin
      verdict_d = VERDICT_PASS;
    end else begin
      verdict_d = VERDICT_DROP;
    end
  end

  // checksum folds
  assign ip_f1 = {1'b0, ip_sum_q[15:0]} + {12'd0, ip_sum_q[20:16]};
  assign ip_f2 = {1'b0, ip_f1[15:0]} + {16'd0, ip_f1[16]};
  assign ic_f1 = {1'b0, ic_sum_q[15:0]} + {15'd0, ic_sum_q[17:16]};
  assign ic_f2 = {1'b0, ic_f1[15:0]} + {16'd0, ic_f1[16]};

  // decision and checksum sums, then fold and invert
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verdict_q <= VERDICT_PASS;
    end else if (cmd_i.eval_sum) begin
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_sum) begin
      ip_sum_q <= {1'b0, acc_q} + {5'd0, ident_q} + {5'd0, ttl_q, 8'd0};
      ic_sum_q <= {2'd0, ~{ck_hi_q, ck_lo_q}} + {2'd0, ~{type_q, code_q}} +
                  {10'd0, code_q};
    end
    if (cmd_i.eval_fold) begin
      ip_ck_q <= ~ip_f2[15:0];
      ic_ck_q <= ~ic_f2[15:0];
    end
  end

  assign is_tx = (verdict_q == VERDICT_TX);

  // read address with the mac and ip address swaps
  always_comb begin
    raddr = k_q;
    if (is_tx) begin
      if (k_q < 6'd6) begin
        raddr = k_q + 6'd6;
      end else if (k_q < 6'd12) begin
        raddr = k_q - 6'd6;
      end else if (k_q >= PosSrcIp && k_q < PosDstIp) begin
        raddr = k_q + 6'd4;
      end else if (k_q >= PosDstIp && k_q < 6'(IpEnd)) begin
        raddr = k_q - 6'd4;
      end
    end
  end

  // field substitution for the echo reply
  always_comb begin
    sub_byte = rdata;
    if (is_tx) begin
      case (k_q)
        PosIdHi:   sub_byte = ident_q[15:8];
        PosIdLo:   sub_byte = ident_q[7:0];
        PosTtl:    sub_byte = ttl_q;
        PosIpCkHi: sub_byte = ip_ck_q[15:8];
        PosIpCkLo: sub_byte = ip_ck_q[7:0];
        PosType:   sub_byte = IcmpEchoRep;
        PosIcCkHi: sub_byte = ic_ck_q[15:8];
        PosIcCkLo: sub_byte = ic_ck_q[7:0];
        default:   sub_byte = rdata;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld || cmd_i.pass_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.out_byte <= sub_byte;
      out_q.out_last <= last_q && status_o.k_last;
      out_q.verdict  <= verdict_q;
    end else if (cmd_i.pass_ld) begin
      out_q.out_byte <= in_item_i.frame_byte;
      out_q.out_last <= in_item_i.frame_last;
      out_q.verdict  <= verdict_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // status
  assign status_o.pos_last   = (pos_q == PosLast);
  assign status_o.k_last     = ((k_q + 6'd1) == pos_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.frame_last = last_q;

endmodule

@@ rtl/core/icmpe_ctrl.sv @@
module icmpe_ctrl
  import icmpe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] SCollect = 3'd0;
  localparam logic [2:0] SEvalSum = 3'd1;
  localparam logic [2:0] SEvalFld = 3'd2;
  localparam logic [2:0] SRead    = 3'd3;
  localparam logic [2:0] SLoad    = 3'd4;
  localparam logic [2:0] SPass    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       in_acc;

  // input stall: open while collecting, and in pass-through when the output can take an item
  always_comb begin
    case (state_q)
      SCollect: in_stall_o = 1'b0;
      SPass:    in_stall_o = !status_i.out_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    case (state_q)
      SCollect: begin
        if (in_acc) begin
          cmd_o.collect_wr = 1'b1;
          if (in_last_i || status_i.pos_last) begin
            state_d = SEvalSum;
          end
        end
      end
      SEvalSum: begin
        cmd_o.eval_sum = 1'b1;
        state_d        = SEvalFld;
      end
      SEvalFld: begin
        cmd_o.eval_fold = 1'b1;
        state_d         = SRead;
      end
      SRead: begin
        if (status_i.out_free) begin
          state_d = SLoad;
        end
      end
      SLoad: begin
        cmd_o.out_ld = 1'b1;
        if (!status_i.k_last) begin
          state_d = SRead;
        end else if (status_i.frame_last) begin
          cmd_o.frame_reset = 1'b1;
          state_d           = SCollect;
        end else begin
          state_d = SPass;
        end
      end
      SPass: begin
        if (in_acc) begin
          cmd_o.pass_ld = 1'b1;
          if (in_last_i) begin
            cmd_o.frame_reset = 1'b1;
            state_d           = SCollect;
          end
        end
      end
      default: begin
        state_d = SCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCollect;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/icmp_echo_responder.sv @@
// channel   direction  handshake            payload
// in        input      in_valid_i/stall_o   in_item_t (frame_byte, frame_last)
// out       output     out_valid_o/stall_i  out_item_t (out_byte, out_last, verdict)
// cfg       input      cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// header bytes (up to 42) are taken one per cycle into the header ram,
// then the eval-sum and eval-fold states decide the verdict and fold the checksums.
// each held byte is then emitted by a ram read state and an output load state,
// split for the registered read port; later bytes pass at one per cycle unless out stalls.
// reset clears the controller, counters and output valid; config resets to ttl 64, id 24851.
// out stall holds the output register and, in pass-through, stalls the input.
module icmp_echo_responder
  import icmpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  icmpe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_item_i.frame_last),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // header store, checksums and output register
  icmpe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule
